// ===== rtl/ofb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ofb_pkg
// Shared types and constants of the overlapping frame buffer.
// ----------------------------------------------------------------------------
package ofb_pkg;

	localparam int SAMPLE_W         = 64;
	localparam int FRAME_LENGTH_W   = 7;
	localparam int OVERLAP_LENGTH_W = 6;
	localparam int CFG_DATA_W       = 7;
	localparam int CFG_INDEX_W      = 1;

	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_LENGTH   = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_OVERLAP_LENGTH = 1'b1;

	localparam logic [FRAME_LENGTH_W-1:0]   FRAME_LENGTH_RESET   = 7'd8;
	localparam logic [OVERLAP_LENGTH_W-1:0] OVERLAP_LENGTH_RESET = 6'd0;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                final_sample;
	} in_word_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] value;
		logic                frame_end;
		logic                run_last;
	} out_word_t;

	// control of the history chain
	typedef struct packed {
		logic shift;
		logic clear;
	} hist_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_REPLAY = 4'b0010,
		ST_SAMPLE = 4'b0100,
		ST_PAD    = 4'b1000
	} seq_state_t;

endpackage
`default_nettype wire

// ===== rtl/ofb_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ofb_cell
// One word of the history chain: loads its neighbor's word on a shift, clears to zero on a clear.
// ----------------------------------------------------------------------------
module ofb_cell
	import ofb_pkg::*;
#(
	parameter int WIDTH = 64
) (
	input  wire              clk,
	input  wire              arst_n,
	input  hist_ctl_t        ctl,
	input  wire  [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else if (ctl.clear) begin
			word_q <= '0;
		end else if (ctl.shift) begin
			word_q <= d;
		end
	end

	assign q = word_q;

endmodule
`default_nettype wire

// ===== rtl/ofb_history.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ofb_history
// Chain of cells holding the most recently emitted words, oldest at cell 0,
// with one selectable read tap.
// ----------------------------------------------------------------------------
module ofb_history
	import ofb_pkg::*;
#(
	parameter int DEPTH = 63,
	parameter int WIDTH = 64,
	parameter int IDX_W = 6
) (
	input  wire              clk,
	input  wire              arst_n,
	input  hist_ctl_t        ctl,
	input  wire  [WIDTH-1:0] push,
	input  wire  [IDX_W-1:0] tap_idx,
	output logic [WIDTH-1:0] tap
);

	logic [WIDTH-1:0] word [DEPTH];

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic [WIDTH-1:0] d;
		if (k == DEPTH - 1) begin : g_last
			assign d = push;
		end else begin : g_mid
			assign d = word[k+1];
		end
		ofb_cell #(
			.WIDTH(WIDTH)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (ctl),
			.d     (d),
			.q     (word[k])
		);
	end

	always_comb begin
		tap = '0;
		if (int'(tap_idx) < DEPTH) begin
			tap = word[tap_idx];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/overlapping_frame_buffer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// overlapping_frame_buffer_unit
// Cuts a word stream into overlapping frames, replaying overlap from a chain
// of history cells and padding the last frame with zeros.
// ----------------------------------------------------------------------------
// One input word at a time: an accepted word is taken in while the unit is
// idle, then each word it causes is emitted in turn (overlap replay at the
// start of a frame, the sample, zero padding after a final sample); no new
// word is accepted until the last is emitted. The output register emits one
// word per cycle while the receiver keeps up; every emitted word shifts into
// the history chain. A final sample clears the history along with its last
// word (the sample or the last padding word), so there is no clearing pass.
module overlapping_frame_buffer_unit
	import ofb_pkg::*;
#(
	parameter int MAX_FRAME = 64,
	parameter int WORD_BITS = 64
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_ready,
	input  in_word_t                in_data,
	output logic                    out_valid,
	input  wire                     out_ready,
	output out_word_t               out_data,
	input  wire                     cfg_we,
	input  wire  [CFG_INDEX_W-1:0]  cfg_index,
	input  wire  [CFG_DATA_W-1:0]   cfg_data
);

	localparam int HIST_DEPTH = MAX_FRAME - 1;
	localparam int IDX_W      = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
	localparam int FL_W       = $clog2(MAX_FRAME + 1);
	localparam int NC_W       = $clog2(MAX_FRAME);

	logic [FRAME_LENGTH_W-1:0]   frame_length_q;
	logic [OVERLAP_LENGTH_W-1:0] overlap_length_q;

	seq_state_t       state_q;
	logic [NC_W-1:0]  new_count_q;
	logic             first_frame_q;
	logic [FL_W-1:0]  cnt_q;
	logic [FL_W-1:0]  inc_q;
	logic [IDX_W-1:0] tap_idx_q;
	logic [WORD_BITS-1:0] sample_q;
	logic             fin_q;

	logic             out_valid_q;
	out_word_t        out_q;

	logic [FL_W-1:0]  flen_eff;
	logic [FL_W-1:0]  ov_eff;
	logic [FL_W-1:0]  inc_c;
	logic [IDX_W-1:0] tap_idx_c;
	logic [FL_W-1:0]  nc_next;
	logic             closes;
	logic             adv;
	logic             emit;
	logic             accept;
	logic             cnt_last;
	logic [WORD_BITS-1:0] emit_word;
	logic             emit_end;
	logic             emit_last;
	logic [WORD_BITS-1:0] tap;
	hist_ctl_t        hist_ctl;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_length_q   <= FRAME_LENGTH_RESET;
			overlap_length_q <= OVERLAP_LENGTH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_LENGTH: begin
					frame_length_q <= cfg_data[FRAME_LENGTH_W-1:0];
				end
				REG_OVERLAP_LENGTH: begin
					overlap_length_q <= cfg_data[OVERLAP_LENGTH_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// effective frame geometry
	always_comb begin
		if (frame_length_q == '0) begin
			flen_eff = FL_W'(1);
		end else if (int'(frame_length_q) > MAX_FRAME) begin
			flen_eff = FL_W'(MAX_FRAME);
		end else begin
			flen_eff = FL_W'(frame_length_q);
		end
		if (int'(overlap_length_q) > int'(flen_eff) - 1) begin
			ov_eff = flen_eff - FL_W'(1);
		end else begin
			ov_eff = FL_W'(overlap_length_q);
		end
		inc_c     = flen_eff - ov_eff;
		// oldest overlap word sits this far into the chain
		tap_idx_c = IDX_W'(HIST_DEPTH - int'(ov_eff));
	end

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign adv      = !out_valid_q || out_ready;
	assign emit     = adv && (state_q != ST_IDLE);
	assign nc_next  = FL_W'(new_count_q) + FL_W'(1);
	assign closes   = (nc_next >= inc_q);
	assign cnt_last = (cnt_q == FL_W'(1));

	always_comb begin
		emit_word = '0;
		emit_end  = 1'b0;
		emit_last = 1'b0;
		unique case (state_q)
			ST_REPLAY: begin
				emit_word = first_frame_q ? '0 : tap;
			end
			ST_SAMPLE: begin
				emit_word = sample_q;
				emit_end  = closes;
				emit_last = !fin_q || closes;
			end
			ST_PAD: begin
				emit_end  = cnt_last;
				emit_last = cnt_last;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		hist_ctl.shift = emit;
		hist_ctl.clear = emit && (((state_q == ST_SAMPLE) && fin_q && closes) ||
			((state_q == ST_PAD) && cnt_last));
	end

	ofb_history #(
		.DEPTH(HIST_DEPTH),
		.WIDTH(WORD_BITS),
		.IDX_W(IDX_W)
	) u_history (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (hist_ctl),
		.push   (emit_word),
		.tap_idx(tap_idx_q),
		.tap    (tap)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			new_count_q   <= '0;
			first_frame_q <= 1'b1;
			cnt_q         <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if ((new_count_q == '0) && (ov_eff != '0)) begin
							state_q <= ST_REPLAY;
							cnt_q   <= ov_eff;
						end else begin
							state_q <= ST_SAMPLE;
						end
					end
				end
				ST_REPLAY: begin
					if (emit) begin
						cnt_q <= cnt_q - FL_W'(1);
						if (cnt_last) begin
							state_q <= ST_SAMPLE;
						end
					end
				end
				ST_SAMPLE: begin
					if (emit) begin
						if (closes) begin
							new_count_q   <= '0;
							first_frame_q <= 1'b0;
						end else begin
							new_count_q <= NC_W'(nc_next);
						end
						if (fin_q && closes) begin
							first_frame_q <= 1'b1;
							state_q       <= ST_IDLE;
						end else if (fin_q) begin
							cnt_q   <= inc_q - nc_next;
							state_q <= ST_PAD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_PAD: begin
					if (emit) begin
						cnt_q <= cnt_q - FL_W'(1);
						if (cnt_last) begin
							new_count_q   <= '0;
							first_frame_q <= 1'b1;
							state_q       <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// per-item payload, captured on accept
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q  <= in_data.sample[WORD_BITS-1:0];
			fin_q     <= in_data.final_sample;
			inc_q     <= inc_c;
			tap_idx_q <= tap_idx_c;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.value     <= SAMPLE_W'(emit_word);
			out_q.frame_end <= emit_end;
			out_q.run_last  <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

// ===== tb/sv/overlapping_frame_buffer_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overlapping_frame_buffer_unit_tb
// Drives sample words through the frame buffer under random valid/ready
// pressure and checks every frame word against an in-testbench model of the
// framing, overlap replay, zero padding and history.
// ----------------------------------------------------------------------------
module overlapping_frame_buffer_unit_tb;
	import ofb_pkg::*;

	localparam int MAX_FRAME   = 64;
	localparam int WORD_BITS   = 64;
	localparam int HIST_DEPTH  = MAX_FRAME - 1;
	localparam int STALL_LIMIT = 4000;
	localparam int PHASE_ITEMS = 98;

	// tracks framing state and builds the frame words each sample must produce
	class frame_predictor;
		logic [SAMPLE_W-1:0]         history [HIST_DEPTH];
		int unsigned                 fill_count;
		bit                          first_frame;
		logic [FRAME_LENGTH_W-1:0]   frame_len_reg;
		logic [OVERLAP_LENGTH_W-1:0] overlap_reg;
		out_word_t                   expected_words [$];
		int                          errors;

		function new();
			frame_len_reg = FRAME_LENGTH_RESET;
			overlap_reg   = OVERLAP_LENGTH_RESET;
			errors        = 0;
			clear_state();
		endfunction

		function void clear_state();
			foreach (history[i]) history[i] = '0;
			fill_count  = 0;
			first_frame = 1'b1;
		endfunction

		function void push_word(logic [SAMPLE_W-1:0] v, bit end_flag);
			out_word_t w;
			w.value     = v;
			w.frame_end = end_flag;
			w.run_last  = 1'b0;
			expected_words.push_back(w);
			for (int i = 0; i < HIST_DEPTH - 1; i++) history[i] = history[i + 1];
			history[HIST_DEPTH - 1] = v;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_FRAME_LENGTH) begin
				frame_len_reg = data[FRAME_LENGTH_W-1:0];
			end else begin
				overlap_reg = data[OVERLAP_LENGTH_W-1:0];
			end
		endfunction

		function void note_sample(in_word_t w);
			int unsigned         flen;
			int unsigned         ov;
			int unsigned         step;
			bit                  closed;
			logic [SAMPLE_W-1:0] replay [$];
			out_word_t           tail;
			flen = 32'(frame_len_reg);
			if (flen == 0) flen = 1;
			if (flen > MAX_FRAME) flen = MAX_FRAME;
			ov = 32'(overlap_reg);
			if (ov > flen - 1) ov = flen - 1;
			step = flen - ov;
			closed = 1'b0;
			// overlap is taken before any word of this sample enters the history
			if (fill_count == 0) begin
				for (int i = 0; i < ov; i++)
					replay.push_back(first_frame ? '0 : history[HIST_DEPTH - ov + i]);
				foreach (replay[i]) push_word(replay[i], 1'b0);
			end
			fill_count++;
			if (fill_count >= step) begin
				push_word(w.sample, 1'b1);
				fill_count  = 0;
				first_frame = 1'b0;
				closed      = 1'b1;
			end else begin
				push_word(w.sample, 1'b0);
			end
			if (w.final_sample) begin
				if (!closed) begin
					for (int unsigned i = fill_count; i < step; i++)
						push_word('0, i + 1 == step);
				end
				clear_state();
			end
			tail = expected_words.pop_back();
			tail.run_last = 1'b1;
			expected_words.push_back(tail);
		endfunction

		function void check_word(out_word_t got);
			out_word_t want;
			if (expected_words.size() == 0) begin
				$error("unexpected word: value %h frame_end %b run_last %b",
					got.value, got.frame_end, got.run_last);
				errors++;
				return;
			end
			want = expected_words.pop_front();
			if (got.value !== want.value) begin
				$error("value: expected %h, got %h", want.value, got.value);
				errors++;
			end
			if (got.frame_end !== want.frame_end) begin
				$error("frame_end: expected %b, got %b", want.frame_end, got.frame_end);
				errors++;
			end
			if (got.run_last !== want.run_last) begin
				$error("run_last: expected %b, got %b", want.run_last, got.run_last);
				errors++;
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	in_word_t               in_data;
	logic                   out_valid;
	logic                   out_ready;
	out_word_t              out_data;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	int send_idle_pct;
	int recv_idle_pct;

	frame_predictor frames = new();

	always #10 clk = ~clk;

	overlapping_frame_buffer_unit #(
		.MAX_FRAME(MAX_FRAME),
		.WORD_BITS(WORD_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// all tasks are entered and left at a falling edge
	task automatic send_word(logic [SAMPLE_W-1:0] s, bit fin);
		in_word_t w;
		w.sample       = s;
		w.final_sample = fin;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data  = w;
		do @(posedge clk); while (!in_ready);
		frames.note_sample(w);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		frames.write_reg(idx, data);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// registers change only once every word of the last sample is out
	task automatic configure(logic [CFG_DATA_W-1:0] flen, logic [CFG_DATA_W-1:0] ov);
		in_valid = 1'b0;
		while (frames.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		write_reg(REG_FRAME_LENGTH, flen);
		write_reg(REG_OVERLAP_LENGTH, ov);
	endtask

	function automatic logic [SAMPLE_W-1:0] random_sample();
		int r;
		r = $urandom_range(9);
		if (r == 0) return '0;
		if (r == 1) return '1;
		return {$urandom, $urandom};
	endfunction

	task automatic run_random(int count);
		int                    sent;
		int                    seg_len;
		int                    r;
		int                    eff_len;
		logic [CFG_DATA_W-1:0] flen;
		logic [CFG_DATA_W-1:0] ov;
		bit                    fin;
		sent = 0;
		while (sent < count) begin
			r = $urandom_range(99);
			if (r < 6) flen = '0;
			else if (r < 12) flen = CFG_DATA_W'($urandom_range(65, 127));
			else if (r < 18) flen = CFG_DATA_W'(MAX_FRAME);
			else flen = CFG_DATA_W'($urandom_range(1, 16));
			eff_len = (flen == 0) ? 1 : (flen > MAX_FRAME) ? MAX_FRAME : int'(flen);
			// mostly a legal overlap, sometimes anything the port can carry
			if ($urandom_range(99) < 12) ov = CFG_DATA_W'($urandom_range(0, 127));
			else ov = CFG_DATA_W'($urandom_range(0, eff_len - 1));
			configure(flen, ov);
			seg_len = $urandom_range(4, 24);
			if (seg_len > count - sent) seg_len = count - sent;
			for (int k = 0; k < seg_len; k++) begin
				if (k == seg_len - 1) fin = ($urandom_range(99) < 70);
				else fin = ($urandom_range(99) < 4);
				send_word(random_sample(), fin);
				sent++;
			end
		end
	endtask

	// receiver: ready changes at the falling edge, words taken at the rising edge
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready = ($urandom_range(99) >= recv_idle_pct);
			@(posedge clk);
			if (arst_n && out_valid && out_ready) frames.check_word(out_data);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
			else quiet++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		cfg_we        = 1'b0;
		cfg_index     = REG_FRAME_LENGTH;
		cfg_data      = '0;
		send_idle_pct = 22;
		recv_idle_pct = 61;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset values of the registers, first frame replays nothing
		send_word('0, 1'b0);
		send_word('1, 1'b0);
		send_word(64'h0123_4567_89AB_CDEF, 1'b1);

		// half overlap, zero overlap on the first frame, padding after final
		configure(7'd4, 7'd2);
		send_word('0, 1'b0);
		send_word('1, 1'b0);
		send_word(64'h5555_5555_5555_5555, 1'b0);
		send_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
		send_word(64'h0000_0000_DEAD_BEEF, 1'b1);

		// zero frame length acts as one, overlap clamped away
		configure(7'd0, 7'd5);
		send_word(64'h1111_2222_3333_4444, 1'b0);
		send_word(64'h8000_0000_0000_0001, 1'b1);

		// saturated frame length with the widest overlap
		configure(7'd127, 7'h7F);
		send_word(64'hFEDC_BA98_7654_3210, 1'b0);
		send_word('1, 1'b1);

		// leave a frame open, then shrink it so it closes early
		configure(7'd5, 7'd1);
		send_word(64'h0000_0000_0000_0011, 1'b0);
		send_word(64'h0000_0000_0000_0022, 1'b0);
		send_word(64'h0000_0000_0000_0033, 1'b0);
		configure(7'd3, 7'd63);
		send_word(64'h0000_0000_0000_0044, 1'b0);
		send_word(64'h0000_0000_0000_0055, 1'b0);
		send_word(64'h0000_0000_0000_0066, 1'b1);

		// one-word frames, final on a closed frame
		configure(7'd1, 7'd0);
		send_word(64'h7FFF_FFFF_FFFF_FFFE, 1'b1);
		send_word(64'h0000_0000_0000_0001, 1'b1);

		run_random(PHASE_ITEMS);
		send_idle_pct = 61;
		recv_idle_pct = 22;
		run_random(PHASE_ITEMS);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(PHASE_ITEMS);

		in_valid = 1'b0;
		while (frames.pending() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (frames.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/ofb_pkg.sv
rtl/ofb_cell.sv
rtl/ofb_history.sv
rtl/overlapping_frame_buffer_unit.sv
tb/sv/overlapping_frame_buffer_unit_tb.sv
